### sv/pnt_pkg.sv
// shared types, codes and defaults of the pisano note transposer
package pnt_pkg;

   localparam int CHANNELS_DEF = 16;
   localparam int KEYS_DEF     = 128;

   localparam int OPCODE_W  = 2;
   localparam int CHANNEL_W = 4;
   localparam int KEY_W     = 7;
   localparam int PAYLOAD_W = 32;
   localparam int OUT_KEY_W = 9;
   localparam int SEED_W    = 5;
   localparam int MOD_W     = 5;
   localparam int TERM_W    = 6;
   localparam int SUM_W     = TERM_W + 1;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 5;

   localparam logic [OPCODE_W-1:0] OP_NOTE_ON    = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_NOTE_OFF   = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_CHOKE      = 2'd2;
   localparam logic [OPCODE_W-1:0] OP_EXPRESSION = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_SEED_FIRST  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SEED_SECOND = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MODULUS     = 2'd2;

   localparam logic signed [SEED_W-1:0] SEED_FIRST_RST  = 5'sd0;
   localparam logic signed [SEED_W-1:0] SEED_SECOND_RST = 5'sd1;
   localparam logic [MOD_W-1:0]         MODULUS_RST     = 5'd12;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOK
   } pnt_state_type;

endpackage

### sv/pisano_note_transposer.sv
// pisano note transposer top level: control, sequence registers, response register
//
//   port group | dir | handshake          | carries
//   req_*      | in  | req_valid/ready    | opcode, channel, key, payload
//   rsp_*      | out | rsp_valid/ready    | opcode, channel, shifted key, payload
//   csr_*      | in  | csr_we             | seed_first, seed_second, modulus
//
// an event is accepted with a read of its offset table entry, and the
// beat is loaded into the response register once that register is free
// a note-on also waits for the remainder unit, one bit per cycle
// after reset the table is cleared one entry a cycle over all CHANNELS*KEYS
// entries, with req_ready low; csr writes are taken during the sweep
// a stalled response holds one beat while the next event is accepted
module pisano_note_transposer
   import pnt_pkg::*;
#(
   parameter int CHANNELS = CHANNELS_DEF,
   parameter int KEYS     = KEYS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [OPCODE_W-1:0]         req_opcode,
   input  logic [CHANNEL_W-1:0]        req_channel,
   input  logic [KEY_W-1:0]            req_key,
   input  logic [PAYLOAD_W-1:0]        req_payload,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [OPCODE_W-1:0]         rsp_out_opcode,
   output logic [CHANNEL_W-1:0]        rsp_out_channel,
   output logic signed [OUT_KEY_W-1:0] rsp_out_key,
   output logic [PAYLOAD_W-1:0]        rsp_out_payload,
   input  logic                        csr_we,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [CSR_DATA_W-1:0]       csr_wdata
);

   localparam int DEPTH = CHANNELS * KEYS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   pnt_state_type state_ff, state_in;

   logic [AW-1:0]               clr_addr_ff, clr_addr_in;
   logic [OPCODE_W-1:0]         op_ff;
   logic [CHANNEL_W-1:0]        ch_ff;
   logic [KEY_W-1:0]            key_ff;
   logic [PAYLOAD_W-1:0]        pay_ff;
   logic                        inside_ff;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [OPCODE_W-1:0]         rsp_op_ff;
   logic [CHANNEL_W-1:0]        rsp_ch_ff;
   logic signed [OUT_KEY_W-1:0] rsp_key_ff;
   logic [PAYLOAD_W-1:0]        rsp_pay_ff;
   logic signed [SEED_W-1:0]    seed_first_ff, seed_first_in;
   logic signed [SEED_W-1:0]    seed_second_ff, seed_second_in;
   logic [MOD_W-1:0]            modulus_ff, modulus_in;
   logic signed [TERM_W-1:0]    term_now_ff, term_now_in;
   logic signed [TERM_W-1:0]    term_before_ff, term_before_in;

   logic                        accept;
   logic                        emit;
   logic                        rsp_free;
   logic                        req_inside;
   logic                        req_note_on;
   logic [AW-1:0]               slot;
   logic                        tbl_wr_en;
   logic [AW-1:0]               tbl_wr_addr;
   logic signed [TERM_W-1:0]    tbl_wr_data;
   logic signed [TERM_W-1:0]    tbl_rd_data;
   logic signed [TERM_W-1:0]    offset;
   logic signed [OUT_KEY_W-1:0] key_sum;
   logic signed [SUM_W-1:0]     term_sum;
   logic                        rem_done;
   logic signed [TERM_W-1:0]    rem_result;
   logic signed [TERM_W-1:0]    wdata_ext;

   assign req_inside  = ({28'd0, req_channel} < 32'(CHANNELS)) &&
                        ({25'd0, req_key} < 32'(KEYS));
   assign req_note_on = (req_opcode == OP_NOTE_ON);
   assign slot        = AW'(32'(req_channel) * 32'(KEYS) + 32'(req_key));
   assign rsp_free    = !rsp_valid_ff || rsp_ready;
   assign term_sum    = {term_now_ff[TERM_W-1], term_now_ff} +
                        {term_before_ff[TERM_W-1], term_before_ff};
   assign wdata_ext   = {csr_wdata[SEED_W-1], csr_wdata[SEED_W-1:0]};

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_addr_ff == AW'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            if (rsp_free && (op_ff != OP_NOTE_ON || rem_done)) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // outputs of the state machine
   always_comb begin
      req_ready   = 1'b0;
      emit        = 1'b0;
      clr_addr_in = clr_addr_ff;
      tbl_wr_en   = 1'b0;
      tbl_wr_addr = slot;
      tbl_wr_data = term_now_ff;
      case (state_ff)
         ST_CLEAR: begin
            tbl_wr_en   = 1'b1;
            tbl_wr_addr = clr_addr_ff;
            tbl_wr_data = '0;
            clr_addr_in = clr_addr_ff + AW'(1);
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            // note-on stores its offset right away, the read is not needed
            tbl_wr_en = req_valid && req_note_on && req_inside;
         end
         ST_LOOK: begin
            emit = rsp_free && (op_ff != OP_NOTE_ON || rem_done);
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   assign accept = req_valid && req_ready;

   assign offset  = (op_ff == OP_NOTE_ON) ? term_now_ff :
                    (inside_ff ? tbl_rd_data : '0);
   assign key_sum = signed'({2'b00, key_ff}) +
                    {{(OUT_KEY_W-TERM_W){offset[TERM_W-1]}}, offset};

   // csr writes and sequence advance
   always_comb begin
      seed_first_in  = seed_first_ff;
      seed_second_in = seed_second_ff;
      modulus_in     = modulus_ff;
      term_now_in    = term_now_ff;
      term_before_in = term_before_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_SEED_FIRST: begin
               seed_first_in  = csr_wdata[SEED_W-1:0];
               term_now_in    = wdata_ext;
               term_before_in = {seed_second_ff[SEED_W-1], seed_second_ff};
            end
            CSR_SEED_SECOND: begin
               seed_second_in = csr_wdata[SEED_W-1:0];
               term_now_in    = {seed_first_ff[SEED_W-1], seed_first_ff};
               term_before_in = wdata_ext;
            end
            CSR_MODULUS: begin
               modulus_in = csr_wdata[MOD_W-1:0];
            end
            default: begin
               modulus_in = modulus_ff;
            end
         endcase
      end else if (emit && op_ff == OP_NOTE_ON) begin
         term_before_in = term_now_ff;
         term_now_in    = rem_result;
      end
   end

   assign rsp_valid_in = emit ? 1'b1 : (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         clr_addr_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
         seed_first_ff  <= SEED_FIRST_RST;
         seed_second_ff <= SEED_SECOND_RST;
         modulus_ff     <= MODULUS_RST;
         term_now_ff    <= {SEED_FIRST_RST[SEED_W-1], SEED_FIRST_RST};
         term_before_ff <= {SEED_SECOND_RST[SEED_W-1], SEED_SECOND_RST};
      end else begin
         state_ff       <= state_in;
         clr_addr_ff    <= clr_addr_in;
         rsp_valid_ff   <= rsp_valid_in;
         seed_first_ff  <= seed_first_in;
         seed_second_ff <= seed_second_in;
         modulus_ff     <= modulus_in;
         term_now_ff    <= term_now_in;
         term_before_ff <= term_before_in;
      end
      if (accept) begin
         op_ff     <= req_opcode;
         ch_ff     <= req_channel;
         key_ff    <= req_key;
         pay_ff    <= req_payload;
         inside_ff <= req_inside;
      end
      if (emit) begin
         rsp_op_ff  <= op_ff;
         rsp_ch_ff  <= ch_ff;
         rsp_key_ff <= key_sum;
         rsp_pay_ff <= pay_ff;
      end
   end

   pnt_table #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_table (
      .clock   (clock),
      .wr_en   (tbl_wr_en),
      .wr_addr (tbl_wr_addr),
      .wr_data (tbl_wr_data),
      .rd_en   (accept),
      .rd_addr (slot),
      .rd_data (tbl_rd_data)
   );

   pnt_rem u_rem (
      .clock    (clock),
      .reset    (reset),
      .start    (accept && req_note_on),
      .dividend (term_sum),
      .divisor  (modulus_ff),
      .done     (rem_done),
      .result   (rem_result)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_opcode  = rsp_op_ff;
   assign rsp_out_channel = rsp_ch_ff;
   assign rsp_out_key     = rsp_key_ff;
   assign rsp_out_payload = rsp_pay_ff;

   // one event in flight: no beat accepted right after another
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted twice in a row");

   // table clear keeps the request side closed after reset
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("request side open during table clear");

   // sequence only moves on a csr write or a note-on response load
   a_term_moves: assert property (@(posedge clock) disable iff (reset)
      !$stable(term_now_ff) && !$past(reset) |->
         $past(csr_we) || $past(emit && op_ff == OP_NOTE_ON))
      else $error("sequence term changed without cause");

endmodule

### sv/pnt_table.sv
// offset table: one write port, one read port with registered read data
module pnt_table
   import pnt_pkg::*;
#(
   parameter int DEPTH = CHANNELS_DEF * KEYS_DEF,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [AW-1:0]            wr_addr,
   input  logic signed [TERM_W-1:0] wr_data,
   input  logic                     rd_en,
   input  logic [AW-1:0]            rd_addr,
   output logic signed [TERM_W-1:0] rd_data
);

   logic signed [TERM_W-1:0] offset_mem [DEPTH];
   logic signed [TERM_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         offset_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= offset_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/pnt_rem.sv
// truncating remainder unit, restoring division one bit per cycle
module pnt_rem
   import pnt_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic signed [SUM_W-1:0]  dividend,
   input  logic [MOD_W-1:0]         divisor,
   output logic                     done,
   output logic signed [TERM_W-1:0] result
);

   localparam int STEPS = TERM_W;
   localparam int CNT_W = $clog2(STEPS + 1);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 neg_ff, neg_in;
   logic [TERM_W-1:0]    quo_ff, quo_in;
   logic [MOD_W-1:0]     rem_ff, rem_in;
   logic [MOD_W-1:0]     div_ff, div_in;
   logic [TERM_W-1:0]    mag;
   logic [MOD_W:0]       trial;
   logic signed [TERM_W-1:0] rem_ext;

   // magnitude of the dividend fits TERM_W bits, at most 60
   assign mag   = TERM_W'(dividend[SUM_W-1] ? (SUM_W'(0) - dividend) : dividend);
   assign trial = {rem_ff, quo_ff[TERM_W-1]};

   always_comb begin
      busy_in = busy_ff;
      done_in = done_ff;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         done_in = 1'b0;
         cnt_in  = CNT_W'(STEPS);
         neg_in  = dividend[SUM_W-1];
         quo_in  = mag;
         rem_in  = '0;
         // zero modulus acts as one
         div_in  = (divisor == '0) ? MOD_W'(1) : divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[TERM_W-2:0], 1'b0};
         if (trial >= {1'b0, div_ff}) begin
            rem_in = MOD_W'(trial - {1'b0, div_ff});
         end else begin
            rem_in = trial[MOD_W-1:0];
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      neg_ff <= neg_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   // sign follows the dividend
   assign rem_ext = signed'({1'b0, rem_ff});
   assign result  = neg_ff ? (TERM_W'(0) - rem_ext) : rem_ext;
   assign done    = done_ff;

endmodule
